@@ rtl/rcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the radius class scorer.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int DIST_W   = 40;
  localparam int MAG_BITS = 20;
  localparam int CNT_W    = 16;
  localparam int WT_W     = 16;
  localparam int FIT_W    = 34;
  localparam int PROD_W   = CNT_W + WT_W + 1;
  localparam int CFG_W    = 40;
  localparam int IDX_W    = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // 1.0 in Q2.12
  localparam logic signed [13:0] CLASS_ONE = 14'sd4096;
  localparam int CLASS_ONE_W = 14;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RADIUS_SQ     = 2'd0;
  localparam logic [IDX_W-1:0] REG_HIT_WEIGHT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_MISS_WEIGHT   = 2'd2;
  localparam logic [IDX_W-1:0] REG_REJECT_WEIGHT = 2'd3;

  // reset values
  localparam logic [DIST_W-1:0]      RADIUS_SQ_RST     = 40'd8388608;
  localparam logic signed [WT_W-1:0] HIT_WEIGHT_RST    = 16'sd0;
  localparam logic signed [WT_W-1:0] MISS_WEIGHT_RST   = 16'sd256;
  localparam logic signed [WT_W-1:0] REJECT_WEIGHT_RST = 16'sd256;

  // outcome codes
  localparam logic [1:0] OUT_HIT    = 2'd0;
  localparam logic [1:0] OUT_MISS   = 2'd1;
  localparam logic [1:0] OUT_REJECT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] outcome;
    logic       set_end;
    logic       commit;
  } tally_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tally_stat_t;

endpackage

@@ rtl/rcs_square.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_square
// Shared saturating square-of-difference unit, one registered result a cycle.
// ----------------------------------------------------------------------------
module rcs_square #(
  parameter int W = 16
) (
  input  logic                           clk,
  input  logic signed [W-1:0]            op_a,
  input  logic signed [W-1:0]            op_b,
  output logic [rcs_pkg::DIST_W-1:0]     sq
);

  localparam int MW = (W + 1 > rcs_pkg::MAG_BITS) ? W + 1 : rcs_pkg::MAG_BITS;

  logic signed [W:0]              diff;
  logic [W:0]                     mag;
  logic [MW-1:0]                  mag_ext;
  logic [rcs_pkg::MAG_BITS-1:0]   mag_lo;
  logic                           over;

  assign diff    = (W + 1)'(op_a) - (W + 1)'(op_b);
  assign mag     = diff[W] ? (W + 1)'(-diff) : (W + 1)'(diff);
  assign mag_ext = MW'(mag);
  assign mag_lo  = mag_ext[rcs_pkg::MAG_BITS-1:0];
  assign over    = |(mag_ext >> rcs_pkg::MAG_BITS);

  always_ff @(posedge clk) begin
    if (over) begin
      sq <= rcs_pkg::DIST_MAX;
    end else begin
      sq <= rcs_pkg::DIST_W'(mag_lo) * rcs_pkg::DIST_W'(mag_lo);
    end
  end

endmodule

@@ rtl/rcs_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_store
// Pattern output store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcs_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/rcs_tally.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_tally
// Saturating hit / miss / reject counts and the set-end weighted sum.
// ----------------------------------------------------------------------------
module rcs_tally (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rcs_pkg::tally_ctl_t                    ctl,
  output rcs_pkg::tally_stat_t                   stat,
  input  logic signed [rcs_pkg::WT_W-1:0]        hit_weight,
  input  logic signed [rcs_pkg::WT_W-1:0]        miss_weight,
  input  logic signed [rcs_pkg::WT_W-1:0]        reject_weight,
  output logic [rcs_pkg::CNT_W-1:0]              hits,
  output logic [rcs_pkg::CNT_W-1:0]              misses,
  output logic [rcs_pkg::CNT_W-1:0]              rejects,
  output logic signed [rcs_pkg::FIT_W-1:0]       fitness
);

  localparam logic [1:0] STEP_LAST = 2'd3;

  logic                                  busy;
  logic                                  set_end;
  logic [1:0]                            step;
  logic signed [rcs_pkg::PROD_W-1:0]     prod;
  logic signed [rcs_pkg::CNT_W:0]        mul_a;
  logic signed [rcs_pkg::WT_W-1:0]       mul_b;
  logic                                  finish;

  assign finish    = busy && (!set_end || step == STEP_LAST);
  assign stat.busy = busy;
  assign stat.done = finish;

  always_comb begin
    case (step)
      2'd0: begin
        mul_a = $signed({1'b0, hits});
        mul_b = hit_weight;
      end
      2'd1: begin
        mul_a = $signed({1'b0, misses});
        mul_b = miss_weight;
      end
      default: begin
        mul_a = $signed({1'b0, rejects});
        mul_b = reject_weight;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      step    <= 2'd0;
      set_end <= 1'b0;
      hits    <= '0;
      misses  <= '0;
      rejects <= '0;
    end else begin
      if (ctl.start) begin
        busy    <= 1'b1;
        step    <= 2'd0;
        set_end <= ctl.set_end;
        case (ctl.outcome)
          rcs_pkg::OUT_HIT: begin
            if (hits != rcs_pkg::CNT_MAX) hits <= hits + 1'b1;
          end
          rcs_pkg::OUT_MISS: begin
            if (misses != rcs_pkg::CNT_MAX) misses <= misses + 1'b1;
          end
          default: begin
            if (rejects != rcs_pkg::CNT_MAX) rejects <= rejects + 1'b1;
          end
        endcase
      end else if (busy) begin
        if (finish) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
      if (ctl.commit && set_end) begin
        hits    <= '0;
        misses  <= '0;
        rejects <= '0;
      end
    end
  end

  // multiply, then accumulate one step later
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      fitness <= '0;
    end else if (busy && set_end) begin
      prod <= mul_a * mul_b;
      if (step != 2'd0) begin
        fitness <= fitness + rcs_pkg::FIT_W'(prod);
      end
    end
  end

endmodule

@@ rtl/radius_class_scorer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_class_scorer_top
// Pattern scorer: distance to target, one-hot class walk, set fitness.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one output/target element per
// request; last_output ends a pattern, last_pattern with it ends a set.
// Output channel (out_valid / out_stall) gives one result per pattern end.
// Config: cfg_wr_en / cfg_index / cfg_data; the user must write them only
// while idle, the block does not enforce it. Per element: accept, then the
// distance update through the shared squarer. Pattern end, n stored elements:
//   hit:      decide, then the tally, then the result register
//   otherwise a pass for the sum of squared stored values, then class
//             vectors tried one at a time, up to n, all on one squarer
//   set end:  the weighted sum on one 17x16 multiplier
// Elements may be accepted while a result waits in the output register; the
// next pattern end waits there until the receiver takes the earlier one.
// Reset clears counts, distance and element count and loads the register
// defaults; the output store needs no clearing.
// ----------------------------------------------------------------------------
module radius_class_scorer_top #(
  parameter int MAX_OUTPUTS = 64,
  parameter int VALUE_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [rcs_pkg::IDX_W-1:0]            cfg_index,
  input  logic [rcs_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [VALUE_BITS-1:0]         net_output,
  input  logic signed [VALUE_BITS-1:0]         target_value,
  input  logic                                 last_output,
  input  logic                                 last_pattern,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           outcome,
  output logic [rcs_pkg::CNT_W-1:0]            hit_count,
  output logic [rcs_pkg::CNT_W-1:0]            miss_count,
  output logic [rcs_pkg::CNT_W-1:0]            reject_count,
  output logic signed [rcs_pkg::FIT_W-1:0]     fitness_add,
  output logic                                 set_done
);

  localparam int AW  = $clog2(MAX_OUTPUTS);
  localparam int CW  = $clog2(MAX_OUTPUTS + 1);
  localparam int OPW = (VALUE_BITS > rcs_pkg::CLASS_ONE_W) ? VALUE_BITS
                                                           : rcs_pkg::CLASS_ONE_W;
  localparam int TW  = rcs_pkg::DIST_W + CW;
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_OUTPUTS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_P1     = 4'd3;
  localparam logic [3:0] S_P2R    = 4'd4;
  localparam logic [3:0] S_P2A    = 4'd5;
  localparam logic [3:0] S_P2B    = 4'd6;
  localparam logic [3:0] S_P2C    = 4'd7;
  localparam logic [3:0] S_TALLY  = 4'd8;
  localparam logic [3:0] S_FIT    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]                              state;
  logic [rcs_pkg::DIST_W-1:0]              radius_sq;
  logic signed [rcs_pkg::WT_W-1:0]         hit_weight;
  logic signed [rcs_pkg::WT_W-1:0]         miss_weight;
  logic signed [rcs_pkg::WT_W-1:0]         reject_weight;

  logic                                    accept;
  logic                                    room;
  logic [CW-1:0]                           element_count;
  logic [rcs_pkg::DIST_W-1:0]              target_distance;
  logic [rcs_pkg::DIST_W:0]                dist_sum;
  logic                                    add_pend;
  logic                                    last_out;
  logic                                    last_pat;

  logic [CW-1:0]                           idx;
  logic                                    rd_pend;
  logic                                    sq_pend;
  logic [TW-1:0]                           sum_sq;
  logic signed [VALUE_BITS-1:0]            rd_data;
  logic signed [VALUE_BITS-1:0]            s_val;
  logic [rcs_pkg::DIST_W-1:0]              a_sq;
  logic [TW:0]                             cand;
  logic [1:0]                              result;

  logic signed [OPW-1:0]                   op_a;
  logic signed [OPW-1:0]                   op_b;
  logic [rcs_pkg::DIST_W-1:0]              sq;

  logic                                    out_free;
  rcs_pkg::tally_ctl_t                     tctl;
  rcs_pkg::tally_stat_t                    tstat;
  logic [rcs_pkg::CNT_W-1:0]               t_hits;
  logic [rcs_pkg::CNT_W-1:0]               t_misses;
  logic [rcs_pkg::CNT_W-1:0]               t_rejects;
  logic signed [rcs_pkg::FIT_W-1:0]        t_fitness;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign room     = (element_count < COUNT_FULL);
  assign out_free = !out_valid || !out_stall;
  assign dist_sum = {1'b0, target_distance} + {1'b0, sq};
  // class i distance = sum of all squares - own square + square against 1.0
  assign cand     = (TW + 1)'(sum_sq) + (TW + 1)'(sq) - (TW + 1)'(a_sq);

  always_comb begin
    case (state)
      S_P1, S_P2A: begin
        op_a = '0;
        op_b = OPW'(rd_data);
      end
      S_P2B: begin
        op_a = OPW'(rcs_pkg::CLASS_ONE);
        op_b = OPW'(s_val);
      end
      default: begin
        op_a = OPW'(target_value);
        op_b = OPW'(net_output);
      end
    endcase
  end

  rcs_square #(
    .W (OPW)
  ) u_square (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .sq   (sq)
  );

  rcs_store #(
    .DEPTH (MAX_OUTPUTS),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (element_count[AW-1:0]),
    .wr_data (net_output),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    tctl.start   = (state == S_TALLY);
    tctl.outcome = result;
    tctl.set_end = last_pat;
    tctl.commit  = (state == S_OUT) && out_free;
  end

  rcs_tally u_tally (
    .clk           (clk),
    .rst           (rst),
    .ctl           (tctl),
    .stat          (tstat),
    .hit_weight    (hit_weight),
    .miss_weight   (miss_weight),
    .reject_weight (reject_weight),
    .hits          (t_hits),
    .misses        (t_misses),
    .rejects       (t_rejects),
    .fitness       (t_fitness)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq     <= rcs_pkg::RADIUS_SQ_RST;
      hit_weight    <= rcs_pkg::HIT_WEIGHT_RST;
      miss_weight   <= rcs_pkg::MISS_WEIGHT_RST;
      reject_weight <= rcs_pkg::REJECT_WEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rcs_pkg::REG_RADIUS_SQ:     radius_sq     <= cfg_data[rcs_pkg::DIST_W-1:0];
        rcs_pkg::REG_HIT_WEIGHT:    hit_weight    <= cfg_data[rcs_pkg::WT_W-1:0];
        rcs_pkg::REG_MISS_WEIGHT:   miss_weight   <= cfg_data[rcs_pkg::WT_W-1:0];
        rcs_pkg::REG_REJECT_WEIGHT: reject_weight <= cfg_data[rcs_pkg::WT_W-1:0];
        default: ;
      endcase
    end
  end

  // read pipeline of the first pass: address, store data, square
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      sq_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_P1) && (idx < element_count);
      sq_pend <= rd_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      sum_sq <= '0;
    end else if (sq_pend) begin
      sum_sq <= sum_sq + TW'(sq);
    end
    if (state == S_P2A) s_val <= rd_data;
    if (state == S_P2B) a_sq  <= sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      element_count   <= '0;
      target_distance <= '0;
      add_pend        <= 1'b0;
      last_out        <= 1'b0;
      last_pat        <= 1'b0;
      idx             <= '0;
      result          <= rcs_pkg::OUT_HIT;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            add_pend <= room;
            last_out <= last_output;
            last_pat <= last_pattern;
            if (room) element_count <= element_count + 1'b1;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (add_pend) begin
            target_distance <= dist_sum[rcs_pkg::DIST_W] ? rcs_pkg::DIST_MAX
                                                         : dist_sum[rcs_pkg::DIST_W-1:0];
          end
          state <= last_out ? S_DECIDE : S_IDLE;
        end
        S_DECIDE: begin
          idx <= '0;
          if (target_distance < radius_sq) begin
            result <= rcs_pkg::OUT_HIT;
            state  <= S_TALLY;
          end else begin
            state <= S_P1;
          end
        end
        S_P1: begin
          if (idx < element_count) begin
            idx <= idx + 1'b1;
          end else if (!rd_pend && !sq_pend) begin
            idx   <= '0;
            state <= S_P2R;
          end
        end
        S_P2R: state <= S_P2A;
        S_P2A: state <= S_P2B;
        S_P2B: state <= S_P2C;
        S_P2C: begin
          if (cand < (TW + 1)'(radius_sq)) begin
            result <= rcs_pkg::OUT_MISS;
            state  <= S_TALLY;
          end else if (idx + CW'(1) == element_count) begin
            result <= rcs_pkg::OUT_REJECT;
            state  <= S_TALLY;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_P2R;
          end
        end
        S_TALLY: state <= S_FIT;
        S_FIT: begin
          if (tstat.done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free && !tstat.busy) begin
            out_valid       <= 1'b1;
            element_count   <= '0;
            target_distance <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      outcome      <= result;
      hit_count    <= t_hits;
      miss_count   <= t_misses;
      reject_count <= t_rejects;
      fitness_add  <= t_fitness;
      set_done     <= last_pat;
    end
  end

endmodule
